@@ sv/pks_pkg.sv @@
// Shared types, constants and helpers of the packet key scrambler.
`default_nettype none

package pks_pkg;

    // Packet store geometry.
    localparam int MAX_BYTES = 4096;
    localparam int ADDR_W    = $clog2(MAX_BYTES);
    localparam int CNT_W     = $clog2(MAX_BYTES + 1);

    // Fixed field and register widths.
    localparam int BYTE_W    = 8;
    localparam int KEY_W     = 16;
    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 3;
    localparam int CMD_W     = 2;
    localparam int STATUS_W  = 3;
    localparam int LEN_W     = 13;
    localparam int TAB_WORDS = 4;
    localparam int TAB_IDX_W = 4;

    // Special values.
    localparam logic [KEY_W-1:0]  KEY_UNSET = 16'hffff;
    localparam logic [KEY_W-1:0]  KEY_NONE  = 16'h0000;
    localparam logic [BYTE_W-1:0] HDR_MARK  = 8'hff;
    localparam logic [CFG_W-1:0]  TAB_RST_EVEN = 32'h4456123f;
    localparam logic [CFG_W-1:0]  TAB_RST_ODD  = 32'h4433bb9a;

    // Input commands.
    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD = 2'd0,
        CMD_ENC  = 2'd1,
        CMD_DEC  = 2'd2,
        CMD_READ = 2'd3
    } t_cmd;

    // Run status codes.
    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 3'd0,
        ST_PASS     = 3'd1,
        ST_KEY_UNSET= 3'd2,
        ST_SHORT    = 3'd3,
        ST_MISMATCH = 3'd4,
        ST_OVERFLOW = 3'd5
    } t_status;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KEY  = 3'd0,
        CFG_TAB0 = 3'd1,
        CFG_TAB1 = 3'd2,
        CFG_TAB2 = 3'd3,
        CFG_TAB3 = 3'd4
    } t_cfg_idx;

    // The sixteen key table bytes as four words.
    typedef logic [TAB_WORDS-1:0][CFG_W-1:0] t_tab;

    // Result of the remainder unit.
    typedef struct packed {
        logic              done;
        logic [ADDR_W-1:0] rem;
    } t_mod_res;

    // Pick table byte idx; byte 4*w+b sits in bits 8*b+7..8*b of word w.
    function automatic logic [BYTE_W-1:0] tab_byte(input t_tab tab,
                                                   input logic [TAB_IDX_W-1:0] idx);
        logic [CFG_W-1:0] w;
        w = tab[idx[3:2]] >> {idx[1:0], 3'b000};
        return w[BYTE_W-1:0];
    endfunction

endpackage

`default_nettype wire

@@ sv/pks_in_if.sv @@
// Input channel: command words with valid/ready handshake.
`default_nettype none

interface pks_in_if;
    logic                          valid;
    logic                          ready;
    logic [pks_pkg::CMD_W-1:0]     command;
    logic [pks_pkg::BYTE_W-1:0]    data_byte;

    modport source (output valid, output command, output data_byte, input ready);
    modport sink   (input valid, input command, input data_byte, output ready);
endinterface

`default_nettype wire

@@ sv/pks_out_if.sv @@
// Output channel: result words with valid/ready handshake.
`default_nettype none

interface pks_out_if;
    logic                          valid;
    logic                          ready;
    logic [pks_pkg::BYTE_W-1:0]    out_byte;
    logic                          out_valid;
    logic                          out_last;
    logic [pks_pkg::STATUS_W-1:0]  status;
    logic [pks_pkg::LEN_W-1:0]     result_length;

    modport source (output valid, output out_byte, output out_valid, output out_last,
                    output status, output result_length, input ready);
    modport sink   (input valid, input out_byte, input out_valid, input out_last,
                    input status, input result_length, output ready);
endinterface

`default_nettype wire

@@ sv/packet_key_scrambler.sv @@
// Top level of the packet key scrambler: command sequencer around the packet store.
`default_nettype none

// Packet bytes are loaded into a 4096-byte single-port-write, single-port-read store,
// one byte per cycle on load words while the result words are taken. An encode or
// decode word then rewrites the packet in place; the store is walked byte by byte (read,
// then modify and write). For an n-byte packet that is scrambled, both runs depend on
// the bit-serial remainder unit that computes key modulo n for the swap. A decode
// always waits for it at the start. An encode waits for it only on short packets.
// A pass-through header is found from the first two bytes in states S_HDR0 to S_HDR2,
// which answers it. A load word returns its word in the cycle after it is taken. A read
// word returns the next result byte through the store's registered read port, state
// S_READ and the output register. No new word is taken while a run is busy or while
// the result word waits. Every input word produces exactly one output word, carrying
// the status of the last run and the length of its result, which a later load clears.
// Configuration writes are only legal while the block is idle.
module packet_key_scrambler (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    pks_in_if.sink                               i_in,
    pks_out_if.source                            o_out,
    input  wire logic                            i_cfg_we,
    input  wire logic [pks_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [pks_pkg::CFG_W-1:0]       i_cfg_data
);

    localparam int AW = pks_pkg::ADDR_W;
    localparam int CW = pks_pkg::CNT_W;
    localparam int BW = pks_pkg::BYTE_W;

    typedef enum logic [9:0] {
        S_IDLE  = 10'b00_0000_0001,
        S_READ  = 10'b00_0000_0010,
        S_HDR0  = 10'b00_0000_0100,
        S_HDR1  = 10'b00_0000_1000,
        S_HDR2  = 10'b00_0001_0000,
        S_PASS  = 10'b00_0010_0000,
        S_SW_RA = 10'b00_0100_0000,
        S_SW_RB = 10'b00_1000_0000,
        S_SW_WA = 10'b01_0000_0000,
        S_SW_WB = 10'b10_0000_0000
    } t_state;

    // Control registers.
    t_state                      r_state, n_state;
    logic [CW-1:0]               r_bc, n_bc;
    logic [CW-1:0]               r_rp, n_rp;
    logic [CW-1:0]               r_len, n_len;
    pks_pkg::t_status            r_status, n_status;
    logic                        r_ovf, n_ovf;
    logic                        r_pending, n_pending;
    logic                        r_o_vld;
    logic [pks_pkg::KEY_W-1:0]   r_key;
    pks_pkg::t_tab               r_tab;

    // Run datapath registers.
    logic [CW-1:0]               r_n, n_n;
    logic [CW-1:0]               r_idx, n_idx;
    logic                        r_ph, n_ph;
    logic                        r_enc, n_enc;
    logic [BW-1:0]               r_cs, n_cs;
    logic [BW-1:0]               r_hold, n_hold;
    logic                        r_hdr_ff, n_hdr_ff;
    logic                        r_rlast, n_rlast;

    // Output word register.
    logic [BW-1:0]               r_o_byte;
    logic                        r_o_ov;
    logic                        r_o_last;
    pks_pkg::t_status            r_o_status;
    logic [CW-1:0]               r_o_len;

    // Combinational controls.
    logic                        in_ready;
    logic                        in_acc;
    logic                        mem_we;
    logic [AW-1:0]               mem_waddr;
    logic [BW-1:0]               mem_wdata;
    logic [AW-1:0]               mem_raddr;
    logic [BW-1:0]               mem_rdata;
    logic                        mod_start;
    pks_pkg::t_mod_res           mod_res;
    logic                        out_load;
    logic [BW-1:0]               out_byte;
    logic                        out_ov;
    logic                        out_last;
    logic                        fin;
    pks_pkg::t_status            fin_status;
    logic [CW-1:0]               fin_len;
    logic [BW-1:0]               tab_b;
    logic [BW-1:0]               dec_x;
    logic [CW-1:0]               n_minus1;
    logic                        idx_last;

    pks_ram #(
        .DATA_W (BW),
        .DEPTH  (pks_pkg::MAX_BYTES)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    pks_mod u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (mod_start),
        .i_dividend (r_key),
        .i_divisor  (r_bc),
        .o_res      (mod_res)
    );

    // Handshake: take a word only when idle and the output register is free.
    assign in_ready = (r_state == S_IDLE) && (!r_o_vld || o_out.ready);
    assign in_acc   = i_in.valid && in_ready;

    // Per-byte helpers for the in-place pass.
    assign n_minus1 = CW'(r_n - 1'b1);
    assign idx_last = (r_idx == n_minus1);
    assign tab_b    = pks_pkg::tab_byte(r_tab,
                          pks_pkg::TAB_IDX_W'(r_key[3:0] + r_idx[3:0]));
    assign dec_x    = mem_rdata ^ tab_b;

    // Sequencer and next-state logic.
    always_comb begin
        n_state   = r_state;
        n_bc      = r_bc;
        n_rp      = r_rp;
        n_len     = r_len;
        n_status  = r_status;
        n_ovf     = r_ovf;
        n_pending = r_pending;
        n_n       = r_n;
        n_idx     = r_idx;
        n_ph      = r_ph;
        n_enc     = r_enc;
        n_cs      = r_cs;
        n_hold    = r_hold;
        n_hdr_ff  = r_hdr_ff;
        n_rlast   = r_rlast;

        mem_we     = 1'b0;
        mem_waddr  = r_idx[AW-1:0];
        mem_wdata  = '0;
        mem_raddr  = r_idx[AW-1:0];
        mod_start  = 1'b0;
        out_load   = 1'b0;
        out_byte   = '0;
        out_ov     = 1'b0;
        out_last   = 1'b0;
        fin        = 1'b0;
        fin_status = pks_pkg::ST_OK;
        fin_len    = '0;

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    case (i_in.command)
                        pks_pkg::CMD_LOAD: begin
                            // The first load after a run drops the unread result.
                            if (r_pending) begin
                                n_pending = 1'b0;
                                n_len     = '0;
                                n_rp      = '0;
                            end
                            if (r_bc < CW'(pks_pkg::MAX_BYTES)) begin
                                mem_we    = 1'b1;
                                mem_waddr = r_bc[AW-1:0];
                                mem_wdata = i_in.data_byte;
                                n_bc      = r_bc + 1'b1;
                            end else begin
                                n_ovf = 1'b1;
                            end
                            out_load = 1'b1;
                        end
                        pks_pkg::CMD_ENC, pks_pkg::CMD_DEC: begin
                            n_bc      = '0;
                            n_ovf     = 1'b0;
                            n_rp      = '0;
                            n_pending = 1'b1;
                            n_n       = r_bc;
                            n_enc     = (i_in.command == pks_pkg::CMD_ENC);
                            n_idx     = '0;
                            n_ph      = 1'b0;
                            n_cs      = r_key[BW-1:0];
                            mod_start = 1'b1;
                            if (r_ovf) begin
                                fin        = 1'b1;
                                fin_status = pks_pkg::ST_OVERFLOW;
                            end else if (i_in.command == pks_pkg::CMD_ENC) begin
                                if (r_key == pks_pkg::KEY_UNSET) begin
                                    fin        = 1'b1;
                                    fin_status = pks_pkg::ST_KEY_UNSET;
                                end else if (r_key == pks_pkg::KEY_NONE) begin
                                    fin        = 1'b1;
                                    fin_status = pks_pkg::ST_PASS;
                                    fin_len    = r_bc;
                                end else if (r_bc == '0) begin
                                    fin        = 1'b1;
                                    fin_status = pks_pkg::ST_SHORT;
                                end else if (r_bc == CW'(1)) begin
                                    n_state = S_PASS;
                                end else begin
                                    n_state = S_HDR0;
                                end
                            end else begin
                                if (r_bc <= CW'(1)) begin
                                    fin        = 1'b1;
                                    fin_status = pks_pkg::ST_SHORT;
                                end else if (r_key == pks_pkg::KEY_NONE) begin
                                    fin        = 1'b1;
                                    fin_status = pks_pkg::ST_PASS;
                                    fin_len    = CW'(r_bc - 1'b1);
                                end else begin
                                    n_state = S_SW_RA;
                                end
                            end
                        end
                        pks_pkg::CMD_READ: begin
                            if (r_rp < r_len) begin
                                mem_raddr = r_rp[AW-1:0];
                                n_rp      = r_rp + 1'b1;
                                n_rlast   = (CW'(r_rp + 1'b1) == r_len);
                                n_state   = S_READ;
                            end else begin
                                out_load = 1'b1;
                            end
                        end
                        default: ;
                    endcase
                end
            end

            // Store data for a read word is back.
            S_READ: begin
                out_load = 1'b1;
                out_byte = mem_rdata;
                out_ov   = 1'b1;
                out_last = r_rlast;
                n_state  = S_IDLE;
            end

            // Look at the first two bytes for the pass-through header.
            S_HDR0: begin
                mem_raddr = AW'(0);
                n_state   = S_HDR1;
            end
            S_HDR1: begin
                mem_raddr = AW'(1);
                n_hdr_ff  = (mem_rdata == pks_pkg::HDR_MARK);
                n_state   = S_HDR2;
            end
            S_HDR2: begin
                if (r_hdr_ff && (mem_rdata == pks_pkg::HDR_MARK)) begin
                    fin        = 1'b1;
                    fin_status = pks_pkg::ST_PASS;
                    fin_len    = r_n;
                end else begin
                    n_state = S_PASS;
                end
            end

            // XOR pass: read a byte, then write it back modified.
            S_PASS: begin
                if (!r_ph) begin
                    n_ph = 1'b1;
                end else begin
                    n_ph   = 1'b0;
                    mem_we = 1'b1;
                    if (r_enc) begin
                        if (!idx_last) begin
                            mem_wdata = mem_rdata ^ tab_b;
                            n_cs      = r_cs ^ mem_rdata;
                            n_idx     = r_idx + 1'b1;
                        end else begin
                            // The last byte becomes the scrambled checksum.
                            mem_wdata = r_cs ^ tab_b;
                            n_state   = S_SW_RA;
                        end
                    end else begin
                        mem_wdata = dec_x;
                        if (!idx_last) begin
                            n_cs  = r_cs ^ dec_x;
                            n_idx = r_idx + 1'b1;
                        end else if (dec_x == r_cs) begin
                            fin        = 1'b1;
                            fin_status = pks_pkg::ST_OK;
                            fin_len    = n_minus1;
                        end else begin
                            fin        = 1'b1;
                            fin_status = pks_pkg::ST_MISMATCH;
                        end
                    end
                end
            end

            // Swap the last byte with byte key mod n.
            S_SW_RA: begin
                mem_raddr = n_minus1[AW-1:0];
                if (mod_res.done) begin
                    n_state = S_SW_RB;
                end
            end
            S_SW_RB: begin
                mem_raddr = mod_res.rem;
                n_hold    = mem_rdata;
                n_state   = S_SW_WA;
            end
            S_SW_WA: begin
                mem_we    = 1'b1;
                mem_waddr = n_minus1[AW-1:0];
                mem_wdata = mem_rdata;
                n_state   = S_SW_WB;
            end
            S_SW_WB: begin
                mem_we    = 1'b1;
                mem_waddr = mod_res.rem;
                mem_wdata = r_hold;
                if (r_enc) begin
                    fin        = 1'b1;
                    fin_status = pks_pkg::ST_OK;
                    fin_len    = r_n;
                end else begin
                    n_state = S_PASS;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase

        // A finished run updates status and length and emits its word.
        if (fin) begin
            n_status = fin_status;
            n_len    = fin_len;
            out_load = 1'b1;
            n_state  = S_IDLE;
        end
    end

    // Control registers and configuration.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_bc      <= '0;
            r_rp      <= '0;
            r_len     <= '0;
            r_status  <= pks_pkg::ST_OK;
            r_ovf     <= 1'b0;
            r_pending <= 1'b0;
            r_o_vld   <= 1'b0;
            r_key     <= pks_pkg::KEY_NONE;
            r_tab[0]  <= pks_pkg::TAB_RST_EVEN;
            r_tab[1]  <= pks_pkg::TAB_RST_ODD;
            r_tab[2]  <= pks_pkg::TAB_RST_EVEN;
            r_tab[3]  <= pks_pkg::TAB_RST_ODD;
        end else begin
            r_state   <= n_state;
            r_bc      <= n_bc;
            r_rp      <= n_rp;
            r_len     <= n_len;
            r_status  <= n_status;
            r_ovf     <= n_ovf;
            r_pending <= n_pending;
            if (out_load) begin
                r_o_vld <= 1'b1;
            end else if (o_out.ready) begin
                r_o_vld <= 1'b0;
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    pks_pkg::CFG_KEY:  r_key    <= i_cfg_data[pks_pkg::KEY_W-1:0];
                    pks_pkg::CFG_TAB0: r_tab[0] <= i_cfg_data;
                    pks_pkg::CFG_TAB1: r_tab[1] <= i_cfg_data;
                    pks_pkg::CFG_TAB2: r_tab[2] <= i_cfg_data;
                    pks_pkg::CFG_TAB3: r_tab[3] <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // Run datapath and output payload.
    always_ff @(posedge i_clk) begin
        r_n      <= n_n;
        r_idx    <= n_idx;
        r_ph     <= n_ph;
        r_enc    <= n_enc;
        r_cs     <= n_cs;
        r_hold   <= n_hold;
        r_hdr_ff <= n_hdr_ff;
        r_rlast  <= n_rlast;
        if (out_load) begin
            r_o_byte   <= out_byte;
            r_o_ov     <= out_ov;
            r_o_last   <= out_last;
            r_o_status <= n_status;
            r_o_len    <= n_len;
        end
    end

    assign i_in.ready          = in_ready;
    assign o_out.valid         = r_o_vld;
    assign o_out.out_byte      = r_o_byte;
    assign o_out.out_valid     = r_o_ov;
    assign o_out.out_last      = r_o_last;
    assign o_out.status        = r_o_status;
    assign o_out.result_length = pks_pkg::LEN_W'(r_o_len);

endmodule

`default_nettype wire

@@ sv/pks_ram.sv @@
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none

module pks_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 4096
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [DATA_W-1:0]        i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [DATA_W-1:0]        o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, registered.
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

@@ sv/pks_mod.sv @@
// Bit-serial remainder unit: key modulo packet length, one dividend bit per cycle.
`default_nettype none

module pks_mod (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic [pks_pkg::KEY_W-1:0]     i_dividend,
    input  wire logic [pks_pkg::CNT_W-1:0]     i_divisor,
    output pks_pkg::t_mod_res                  o_res
);

    localparam int STEP_W = $clog2(pks_pkg::KEY_W);

    logic                        r_busy;
    logic [STEP_W-1:0]           r_cnt;
    logic [pks_pkg::KEY_W-1:0]   r_dvd;
    logic [pks_pkg::ADDR_W-1:0]  r_rem;
    logic [pks_pkg::ADDR_W:0]    r_div;

    logic [pks_pkg::ADDR_W:0]    trial;
    logic [pks_pkg::ADDR_W-1:0]  n_rem;

    // One restoring step: shift in the next dividend bit and subtract if it fits.
    always_comb begin
        trial = {r_rem, r_dvd[pks_pkg::KEY_W-1]};
        if (trial >= r_div) begin
            n_rem = pks_pkg::ADDR_W'(trial - r_div);
        end else begin
            n_rem = trial[pks_pkg::ADDR_W-1:0];
        end
    end

    // Step sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == STEP_W'(pks_pkg::KEY_W - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    // Datapath.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_rem <= '0;
            r_div <= (pks_pkg::ADDR_W + 1)'(i_divisor);
        end else if (r_busy) begin
            r_dvd <= {r_dvd[pks_pkg::KEY_W-2:0], 1'b0};
            r_rem <= n_rem;
        end
    end

    assign o_res.done = !r_busy && !i_start;
    assign o_res.rem  = r_rem;

endmodule

`default_nettype wire

@@ tb/pks_scramble_checker.sv @@
// Checker for the packet key scrambler: predicts every result word and compares it.
module pks_scramble_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    pks_in_if                             i_in_ch,
    pks_out_if                            i_out_ch,
    input  logic                          i_cfg_we,
    input  logic [pks_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [pks_pkg::CFG_W-1:0]     i_cfg_data,
    output int                            o_fail_count,
    output int                            o_pending
);

    // One result word as the block presents it.
    typedef struct packed {
        logic [pks_pkg::BYTE_W-1:0]   out_byte;
        logic                         out_valid;
        logic                         out_last;
        logic [pks_pkg::STATUS_W-1:0] status;
        logic [pks_pkg::LEN_W-1:0]    result_length;
    } t_result_word;

    // Shadow copy of the block's packet store, counters and registers.
    logic [pks_pkg::BYTE_W-1:0] pkt_mem [pks_pkg::MAX_BYTES];
    int unsigned                fill_cnt;
    int unsigned                rd_ptr;
    int unsigned                res_len;
    pks_pkg::t_status           run_status;
    bit                         overrun;
    bit                         unread;
    logic [pks_pkg::KEY_W-1:0]  sess_key;
    logic [pks_pkg::CFG_W-1:0]  tab_w [pks_pkg::TAB_WORDS];

    t_result_word      expected_words [$];
    int                mismatch_count;
    int                words_seen;

    // Table byte selected by a four-bit slot number.
    function automatic logic [pks_pkg::BYTE_W-1:0] mask_byte(
        input logic [pks_pkg::TAB_IDX_W-1:0] slot);
        logic [pks_pkg::CFG_W-1:0] word;
        word = tab_w[slot[3:2]];
        return word[{slot[1:0], 3'b000} +: pks_pkg::BYTE_W];
    endfunction

    // XOR every byte with the table byte picked by key plus position.
    function automatic void mask_pass(input int unsigned n);
        for (int unsigned i = 0; i < n; i++) begin
            pkt_mem[i] = pkt_mem[i] ^ mask_byte(sess_key[3:0] + i[3:0]);
        end
    endfunction

    // Exchange the tail byte with the byte at key modulo size.
    function automatic void swap_tail(input int unsigned n);
        int unsigned                j;
        logic [pks_pkg::BYTE_W-1:0] t;
        j = sess_key % n;
        t = pkt_mem[n-1];
        pkt_mem[n-1] = pkt_mem[j];
        pkt_mem[j] = t;
    endfunction

    // Checksum over all bytes but the last, seeded with the key's low byte.
    function automatic logic [pks_pkg::BYTE_W-1:0] tail_sum(input int unsigned n);
        logic [pks_pkg::BYTE_W-1:0] cs;
        cs = sess_key[pks_pkg::BYTE_W-1:0];
        for (int unsigned i = 0; i + 1 < n; i++) begin
            cs = cs ^ pkt_mem[i];
        end
        return cs;
    endfunction

    function automatic void encode_packet(input int unsigned n);
        if (sess_key == pks_pkg::KEY_UNSET) begin
            run_status = pks_pkg::ST_KEY_UNSET;
            res_len = 0;
            return;
        end
        // A 0xff 0xff header or a zero key leaves the packet as it is.
        if ((n >= 2 && pkt_mem[0] == pks_pkg::HDR_MARK && pkt_mem[1] == pks_pkg::HDR_MARK)
            || sess_key == pks_pkg::KEY_NONE) begin
            run_status = pks_pkg::ST_PASS;
            res_len = n;
            return;
        end
        if (n == 0) begin
            run_status = pks_pkg::ST_SHORT;
            res_len = 0;
            return;
        end
        pkt_mem[n-1] = tail_sum(n);
        mask_pass(n);
        swap_tail(n);
        run_status = pks_pkg::ST_OK;
        res_len = n;
    endfunction

    function automatic void decode_packet(input int unsigned n);
        if (n <= 1) begin
            run_status = pks_pkg::ST_SHORT;
            res_len = 0;
            return;
        end
        if (sess_key == pks_pkg::KEY_NONE) begin
            run_status = pks_pkg::ST_PASS;
            res_len = n - 1;
            return;
        end
        swap_tail(n);
        mask_pass(n);
        if (pkt_mem[n-1] != tail_sum(n)) begin
            run_status = pks_pkg::ST_MISMATCH;
            res_len = 0;
            return;
        end
        run_status = pks_pkg::ST_OK;
        res_len = n - 1;
    endfunction

    // Advance the shadow state by one input word and return the word it yields.
    function automatic t_result_word predict_word(input pks_pkg::t_cmd cmd,
                                                  input logic [pks_pkg::BYTE_W-1:0] data);
        t_result_word w;
        w = '0;
        case (cmd)
            pks_pkg::CMD_LOAD: begin
                // The first load after a run drops whatever was left unread.
                if (unread) begin
                    unread = 1'b0;
                    res_len = 0;
                    rd_ptr = 0;
                end
                if (fill_cnt < pks_pkg::MAX_BYTES) begin
                    pkt_mem[fill_cnt] = data;
                    fill_cnt++;
                end else begin
                    overrun = 1'b1;
                end
            end
            pks_pkg::CMD_ENC, pks_pkg::CMD_DEC: begin
                if (overrun) begin
                    run_status = pks_pkg::ST_OVERFLOW;
                    res_len = 0;
                end else if (cmd == pks_pkg::CMD_ENC) begin
                    encode_packet(fill_cnt);
                end else begin
                    decode_packet(fill_cnt);
                end
                fill_cnt = 0;
                overrun = 1'b0;
                rd_ptr = 0;
                unread = 1'b1;
            end
            default: begin
                if (rd_ptr < res_len) begin
                    w.out_byte = pkt_mem[rd_ptr];
                    w.out_valid = 1'b1;
                    w.out_last = (rd_ptr + 1 == res_len);
                    rd_ptr++;
                end
            end
        endcase
        w.status = run_status;
        w.result_length = pks_pkg::LEN_W'(res_len);
        return w;
    endfunction

    // Track register writes, compare result words and queue predictions.
    always @(posedge i_clk) begin
        t_result_word got;
        t_result_word want;
        if (!i_rst_n) begin
            sess_key = pks_pkg::KEY_NONE;
            tab_w[0] = pks_pkg::TAB_RST_EVEN;
            tab_w[1] = pks_pkg::TAB_RST_ODD;
            tab_w[2] = pks_pkg::TAB_RST_EVEN;
            tab_w[3] = pks_pkg::TAB_RST_ODD;
            fill_cnt = 0;
            rd_ptr = 0;
            res_len = 0;
            run_status = pks_pkg::ST_OK;
            overrun = 1'b0;
            unread = 1'b0;
            expected_words.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    pks_pkg::CFG_KEY:  sess_key = i_cfg_data[pks_pkg::KEY_W-1:0];
                    pks_pkg::CFG_TAB0: tab_w[0] = i_cfg_data;
                    pks_pkg::CFG_TAB1: tab_w[1] = i_cfg_data;
                    pks_pkg::CFG_TAB2: tab_w[2] = i_cfg_data;
                    pks_pkg::CFG_TAB3: tab_w[3] = i_cfg_data;
                    default: ;
                endcase
            end

            // A result word must match the oldest prediction in every field.
            if (i_out_ch.valid && i_out_ch.ready) begin
                got.out_byte = i_out_ch.out_byte;
                got.out_valid = i_out_ch.out_valid;
                got.out_last = i_out_ch.out_last;
                got.status = i_out_ch.status;
                got.result_length = i_out_ch.result_length;
                if (expected_words.size() == 0) begin
                    if (mismatch_count < 10) begin
                        $display("result word %0d arrived with nothing expected", words_seen);
                    end
                    mismatch_count++;
                end else begin
                    want = expected_words[0];
                    expected_words.delete(0);
                    if (got !== want) begin
                        if (mismatch_count < 10) begin
                            $display("result word %0d: expected byte %02h valid %0b last %0b",
                                     words_seen, want.out_byte, want.out_valid, want.out_last,
                                     " status %0d length %0d", want.status,
                                     want.result_length);
                            $display("    got byte %02h valid %0b last %0b status %0d length %0d",
                                     got.out_byte, got.out_valid, got.out_last, got.status,
                                     got.result_length);
                        end
                        mismatch_count++;
                    end
                end
                words_seen++;
            end

            if (i_in_ch.valid && i_in_ch.ready) begin
                expected_words.insert(expected_words.size(),
                                      predict_word(pks_pkg::t_cmd'(i_in_ch.command),
                                                   i_in_ch.data_byte));
            end
        end
        o_fail_count <= mismatch_count;
        o_pending <= expected_words.size();
    end

endmodule

@@ tb/packet_key_scrambler_tb.sv @@
// Testbench top of the packet key scrambler: stimulus, flow control and verdict.
module packet_key_scrambler_tb;

    localparam int RANDOM_WORDS = 1250;
    localparam int PHASES       = 10;
    localparam int HOLD_CYCLES  = 400;
    localparam int CYCLE_LIMIT  = 4000000;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n;
    logic                          cfg_we;
    logic [pks_pkg::CFG_IDX_W-1:0] cfg_idx;
    logic [pks_pkg::CFG_W-1:0]     cfg_data;
    logic                          rdy_q = 1'b0;

    int                            fail_count;
    int                            pending;
    int                            send_idle_pct;
    int                            recv_stall_pct;
    int                            words_sent;
    int                            packet_bytes;
    int                            settle_cycles = 48;
    int                            hold_req;
    int                            hold_seen;
    int                            hold_left = 0;
    int                            cycle_cnt;
    logic [pks_pkg::BYTE_W-1:0]    echo_bytes [$];

    pks_in_if  in_ch ();
    pks_out_if out_ch ();

    packet_key_scrambler dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch),
        .o_out      (out_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    pks_scramble_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_ch      (in_ch),
        .i_out_ch     (out_ch),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Long receiver hold-off, started by a change of hold_req.
    always @(posedge i_clk) begin
        if (hold_req != hold_seen) begin
            hold_seen <= hold_req;
            hold_left <= HOLD_CYCLES;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // Receiver takes words unless it is stalling at random or held off.
    assign out_ch.ready = rdy_q;
    always @(posedge i_clk) begin
        rdy_q <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
    end

    // Keep every byte read out so that encoded packets can be fed back for decoding.
    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready && out_ch.out_valid) begin
            echo_bytes.insert(echo_bytes.size(), out_ch.out_byte);
        end
    end

    // Run limit.
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Offer one word, with random idle cycles in front, and wait until it is taken.
    task automatic send_word(input pks_pkg::t_cmd cmd, input logic [pks_pkg::BYTE_W-1:0] data);
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.command <= cmd;
        in_ch.data_byte <= data;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        words_sent++;
        // A run walks the whole packet, so remember how long the block may stay busy.
        if (cmd == pks_pkg::CMD_LOAD) begin
            if (packet_bytes <= pks_pkg::MAX_BYTES) packet_bytes++;
        end else if (cmd != pks_pkg::CMD_READ) begin
            settle_cycles = 2 * packet_bytes + 48;
            packet_bytes = 0;
        end
    endtask

    task automatic read_words(input int k);
        repeat (k) send_word(pks_pkg::CMD_READ, 8'($urandom_range(255)));
    endtask

    // Load n random bytes, optionally starting with the 0xff 0xff header.
    task automatic load_packet(input int n, input bit hdr);
        for (int i = 0; i < n; i++) begin
            send_word(pks_pkg::CMD_LOAD,
                      (hdr && i < 2) ? pks_pkg::HDR_MARK : 8'($urandom_range(255)));
        end
    endtask

    // Stop offering and wait until every predicted word has come back.
    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input pks_pkg::t_cfg_idx idx,
                             input logic [pks_pkg::CFG_W-1:0] val);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= val;
        @(posedge i_clk);
    endtask

    // Registers change only once the block has finished all its work.
    task automatic set_config(input logic [pks_pkg::KEY_W-1:0] key_val,
                              input logic [pks_pkg::CFG_W-1:0] t0,
                              input logic [pks_pkg::CFG_W-1:0] t1,
                              input logic [pks_pkg::CFG_W-1:0] t2,
                              input logic [pks_pkg::CFG_W-1:0] t3);
        drain();
        repeat (settle_cycles) @(posedge i_clk);
        write_reg(pks_pkg::CFG_KEY, pks_pkg::CFG_W'(key_val));
        write_reg(pks_pkg::CFG_TAB0, t0);
        write_reg(pks_pkg::CFG_TAB1, t1);
        write_reg(pks_pkg::CFG_TAB2, t2);
        write_reg(pks_pkg::CFG_TAB3, t3);
        cfg_we <= 1'b0;
    endtask

    // Mostly short packets, now and then a longer one.
    function automatic int pick_len();
        int r;
        r = $urandom_range(99);
        if (r < 10) return $urandom_range(2);
        if (r < 85) return $urandom_range(16, 3);
        if (r < 97) return $urandom_range(64, 17);
        return $urandom_range(300, 65);
    endfunction

    // Load, run either way and read a random number of bytes, maybe too many.
    task automatic plain_packet(input int n);
        load_packet(n, $urandom_range(9) == 0);
        send_word(($urandom_range(1) == 0) ? pks_pkg::CMD_ENC : pks_pkg::CMD_DEC,
                  8'($urandom_range(255)));
        read_words($urandom_range(n + 2));
    endtask

    // Encode a packet, read it out, load the encoded bytes back and decode them.
    task automatic round_trip();
        logic [pks_pkg::BYTE_W-1:0] payload [$];
        int                         n;
        int                         pos;
        drain();
        echo_bytes.delete();
        n = pick_len() + 1;
        load_packet(n, $urandom_range(19) == 0);
        send_word(pks_pkg::CMD_ENC, 8'($urandom_range(255)));
        read_words(n);
        drain();
        payload = echo_bytes;
        // Flip one bit now and then so that the checksum no longer matches.
        if (payload.size() != 0 && $urandom_range(4) == 0) begin
            pos = $urandom_range(payload.size() - 1);
            payload[pos] = payload[pos] ^ (8'h01 << $urandom_range(7));
        end
        foreach (payload[i]) send_word(pks_pkg::CMD_LOAD, payload[i]);
        send_word(pks_pkg::CMD_DEC, 8'($urandom_range(255)));
        read_words(payload.size());
    endtask

    // Words with random commands and data.
    task automatic noise_burst();
        repeat ($urandom_range(8, 1)) begin
            send_word(pks_pkg::t_cmd'($urandom_range(3)), 8'($urandom_range(255)));
        end
    endtask

    initial begin
        int                        random_start;
        logic [pks_pkg::KEY_W-1:0] key_pick;
        logic [pks_pkg::CFG_W-1:0] tab_pick [pks_pkg::TAB_WORDS];
        int                        r;

        in_ch.valid <= 1'b0;
        in_ch.command <= pks_pkg::CMD_LOAD;
        in_ch.data_byte <= '0;
        cfg_we <= 1'b0;
        cfg_idx <= pks_pkg::CFG_KEY;
        cfg_data <= '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        i_rst_n <= 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset key is zero: reads with nothing to read, runs that pass through.
        send_word(pks_pkg::CMD_READ, 8'hff);
        send_word(pks_pkg::CMD_LOAD, 8'h00);
        send_word(pks_pkg::CMD_LOAD, 8'hff);
        send_word(pks_pkg::CMD_LOAD, 8'h5a);
        send_word(pks_pkg::CMD_ENC, 8'h00);
        read_words(4);
        load_packet(2, 1'b0);
        send_word(pks_pkg::CMD_DEC, 8'h00);
        read_words(2);

        // Key not yet set: encoding is refused, decoding goes ahead.
        set_config(pks_pkg::KEY_UNSET, pks_pkg::TAB_RST_EVEN, pks_pkg::TAB_RST_ODD,
                   pks_pkg::TAB_RST_EVEN, pks_pkg::TAB_RST_ODD);
        load_packet(2, 1'b0);
        send_word(pks_pkg::CMD_ENC, 8'h00);
        load_packet(2, 1'b0);
        send_word(pks_pkg::CMD_DEC, 8'h00);
        read_words(1);

        // Empty packet, header bypass, too short to decode, one-byte encode.
        set_config(16'h1234, 32'hffffffff, 32'h00000000, 32'hffffffff, 32'h00000000);
        send_word(pks_pkg::CMD_ENC, 8'h00);
        load_packet(3, 1'b1);
        send_word(pks_pkg::CMD_ENC, 8'h00);
        read_words(1);
        load_packet(1, 1'b0);
        send_word(pks_pkg::CMD_DEC, 8'h00);
        load_packet(1, 1'b0);
        send_word(pks_pkg::CMD_ENC, 8'h00);
        read_words(2);

        // Random part, one register setting and one flow-control mode per phase.
        random_start = words_sent;
        for (int p = 0; p < PHASES; p++) begin
            key_pick = pks_pkg::KEY_W'($urandom_range(65535));
            foreach (tab_pick[i]) tab_pick[i] = $urandom();
            case (p)
                0: begin
                    tab_pick[0] = pks_pkg::TAB_RST_EVEN;
                    tab_pick[1] = pks_pkg::TAB_RST_ODD;
                    tab_pick[2] = pks_pkg::TAB_RST_EVEN;
                    tab_pick[3] = pks_pkg::TAB_RST_ODD;
                end
                1: begin
                    key_pick = 16'h0001;
                    foreach (tab_pick[i]) tab_pick[i] = '0;
                end
                2: begin
                    key_pick = 16'hfffe;
                    foreach (tab_pick[i]) tab_pick[i] = '1;
                end
                3: key_pick = pks_pkg::KEY_NONE;
                5: key_pick = pks_pkg::KEY_UNSET;
                default: ;
            endcase
            set_config(key_pick, tab_pick[0], tab_pick[1], tab_pick[2], tab_pick[3]);

            case (p % 4)
                0: begin
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    send_idle_pct = 49;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct = 0;
                    recv_stall_pct = 49;
                end
                default: begin
                    send_idle_pct = 7;
                    recv_stall_pct = 7;
                end
            endcase

            // Hold the receiver off while words keep coming, so the block backs up.
            if (p == 0) begin
                hold_req <= hold_req + 1;
                plain_packet(40);
            end

            while (words_sent < random_start + (p + 1) * (RANDOM_WORDS / PHASES)) begin
                r = $urandom_range(99);
                if (r < 55) round_trip();
                else if (r < 85) plain_packet(pick_len());
                else noise_burst();
            end
        end

        drain();
        repeat (settle_cycles) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

@@ packet_key_scrambler.f @@
sv/pks_pkg.sv
sv/pks_in_if.sv
sv/pks_out_if.sv
sv/pks_ram.sv
sv/pks_mod.sv
sv/packet_key_scrambler.sv
tb/pks_scramble_checker.sv
tb/packet_key_scrambler_tb.sv
